// File: design/ufrm_pkg.sv
package ufrm_pkg;

   localparam int BUF_DEPTH = 64;
   localparam int ADDR_W    = 6;
   localparam int LEN_W     = 7;
   localparam int TICK_W    = 8;
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;

   localparam logic [LEN_W-1:0]  BUF_SIZE_RESET = 7'd64;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET  = 8'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_BUF_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 1'b1;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic REASON_TIMEOUT = 1'b0;
   localparam logic REASON_FULL    = 1'b1;

   typedef struct packed {
      logic [LEN_W-1:0]  buf_size;
      logic [TICK_W-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   function automatic logic [LEN_W-1:0] eff_size(input logic [LEN_W-1:0] size);
      logic [LEN_W-1:0] res;
      res = size;
      if (size == '0) begin
         res = 7'd1;
      end else if (size > LEN_W'(BUF_DEPTH)) begin
         res = LEN_W'(BUF_DEPTH);
      end
      return res;
   endfunction

endpackage

// File: design/ufrm_store.sv
module ufrm_store (
   input  logic                           clock,
   input  ufrm_pkg::mem_req_type          mem_req,
   output logic [ufrm_pkg::BYTE_W-1:0]    rd_data
);

   logic [ufrm_pkg::BYTE_W-1:0] mem_ff [ufrm_pkg::BUF_DEPTH];
   logic [ufrm_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ufrm_ctrl.sv
module ufrm_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  ufrm_pkg::cfg_type                 cfg,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [ufrm_pkg::BYTE_W-1:0]       req_rx_byte,
   output ufrm_pkg::mem_req_type             mem_req,
   input  logic [ufrm_pkg::BYTE_W-1:0]       rd_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ufrm_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic [ufrm_pkg::ADDR_W-1:0]       rsp_out_index,
   output logic [ufrm_pkg::LEN_W-1:0]        rsp_frame_length,
   output logic                              rsp_close_reason,
   output logic                              rsp_last
);

   logic                          open_ff, open_in;
   logic [ufrm_pkg::LEN_W-1:0]    count_ff, count_in;
   logic [ufrm_pkg::TICK_W-1:0]   idle_ff, idle_in;

   logic                          drain_ff, drain_in;
   logic [ufrm_pkg::LEN_W-1:0]    len_ff, len_in;
   logic                          reason_ff, reason_in;
   logic [ufrm_pkg::LEN_W-1:0]    iss_ff, iss_in;
   logic                          pend_ff, pend_in;
   logic [ufrm_pkg::ADDR_W-1:0]   pend_idx_ff, pend_idx_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ufrm_pkg::BYTE_W-1:0]   rsp_byte_ff;
   logic [ufrm_pkg::ADDR_W-1:0]   rsp_index_ff;
   logic [ufrm_pkg::LEN_W-1:0]    rsp_len_ff;
   logic                          rsp_reason_ff;
   logic                          rsp_last_ff;

   logic                          accept;
   logic                          close;
   logic                          close_reason;
   logic [ufrm_pkg::LEN_W-1:0]    close_len;
   logic [ufrm_pkg::LEN_W-1:0]    cur_count;
   logic [ufrm_pkg::TICK_W-1:0]   idle_nx;
   logic                          load;
   logic                          issue;
   logic                          pend_last;

   assign accept    = req_valid && !drain_ff;
   assign req_stall = drain_ff;

   always_comb begin
      open_in         = open_ff;
      count_in        = count_ff;
      idle_in         = idle_ff;
      close           = 1'b0;
      close_reason    = ufrm_pkg::REASON_TIMEOUT;
      close_len       = count_ff;
      cur_count       = open_ff ? count_ff : '0;
      idle_nx         = idle_ff + 8'd1;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = cur_count[ufrm_pkg::ADDR_W-1:0];
      mem_req.wr_data = req_rx_byte;
      mem_req.rd_en   = issue;
      mem_req.rd_addr = iss_ff[ufrm_pkg::ADDR_W-1:0];
      if (accept) begin
         if (req_command == ufrm_pkg::CMD_BYTE) begin
            open_in = 1'b1;
            idle_in = '0;
            if (cur_count < ufrm_pkg::eff_size(cfg.buf_size)) begin
               mem_req.wr_en = 1'b1;
               count_in      = cur_count + 7'd1;
            end else begin
               close        = 1'b1;
               close_reason = ufrm_pkg::REASON_FULL;
               close_len    = cur_count;
            end
         end else if (open_ff) begin
            idle_in = idle_nx;
            if (idle_nx >= cfg.timeout_ticks) begin
               close = 1'b1;
            end
         end
      end
      if (close) begin
         open_in  = 1'b0;
         count_in = '0;
         idle_in  = '0;
      end
   end

   assign load      = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue     = drain_ff && (iss_ff < len_ff) && (!pend_ff || load);
   assign pend_last = ({1'b0, pend_idx_ff} + 7'd1) == len_ff;

   always_comb begin
      len_in      = len_ff;
      reason_in   = reason_ff;
      iss_in      = iss_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      drain_in    = drain_ff;
      if (close) begin
         drain_in  = 1'b1;
         len_in    = close_len;
         reason_in = close_reason;
         iss_in    = '0;
         pend_in   = 1'b0;
      end else if (drain_ff) begin
         iss_in      = issue ? iss_ff + 7'd1 : iss_ff;
         pend_in     = issue || (pend_ff && !load);
         pend_idx_in = issue ? iss_ff[ufrm_pkg::ADDR_W-1:0] : pend_idx_ff;
         drain_in    = (iss_in < len_ff) || pend_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         count_ff     <= '0;
         idle_ff      <= '0;
         drain_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         iss_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         open_ff      <= open_in;
         count_ff     <= count_in;
         idle_ff      <= idle_in;
         drain_ff     <= drain_in;
         pend_ff      <= pend_in;
         iss_ff       <= iss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      reason_ff   <= reason_in;
      pend_idx_ff <= pend_idx_in;
      if (load) begin
         rsp_byte_ff   <= rd_data;
         rsp_index_ff  <= pend_idx_ff;
         rsp_len_ff    <= len_ff;
         rsp_reason_ff <= reason_ff;
         rsp_last_ff   <= pend_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_out_index    = rsp_index_ff;
   assign rsp_frame_length = rsp_len_ff;
   assign rsp_close_reason = rsp_reason_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// File: design/uart_rx_idle_timeout_framer_core.sv
// Serial receive framer: gathers received bytes into frames and emits a
// frame when it closes on idle timeout or on a full buffer.
// Input channel req_*: one word per received byte (command 0) or idle tick
// (command 1), taken when req_valid is high and req_stall is low.
// Result channel rsp_*: one word per stored byte of a closed frame, in order,
// with its index, the frame length, the close reason and a last mark; taken
// when rsp_valid is high and rsp_stall is low.
// Config port csr_*: index 0 is buffer size, index 1 is idle timeout;
// csr_ready is always high.
// Throughput: a word that does not close a frame is taken without a stall. A
// closing word starts a drain that reads the frame store one entry per cycle
// through its single read port; each entry passes the store read register and
// then the output register, and results follow one per cycle. req_stall stays
// high until the last entry of the frame is loaded into the output register.
// While rsp_valid is high, rsp_stall freezes the output register and the store
// read; the drain, and so req_stall, then lasts longer.
// Reset clears the open frame, the counters, the drain and rsp_valid, and
// returns the registers to buffer size 64 and timeout 4.
module uart_rx_idle_timeout_framer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic [ufrm_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ufrm_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic [ufrm_pkg::ADDR_W-1:0]        rsp_out_index,
   output logic [ufrm_pkg::LEN_W-1:0]         rsp_frame_length,
   output logic                               rsp_close_reason,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ufrm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ufrm_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   ufrm_pkg::cfg_type                 cfg_ff, cfg_in;
   ufrm_pkg::mem_req_type             mem_req;
   logic [ufrm_pkg::BYTE_W-1:0]       rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ufrm_pkg::CSR_BUF_SIZE: cfg_in.buf_size = csr_wdata[ufrm_pkg::LEN_W-1:0];
            ufrm_pkg::CSR_TIMEOUT:  cfg_in.timeout_ticks = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buf_size      <= ufrm_pkg::BUF_SIZE_RESET;
         cfg_ff.timeout_ticks <= ufrm_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ufrm_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_rx_byte      (req_rx_byte),
      .mem_req          (mem_req),
      .rd_data          (rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_index    (rsp_out_index),
      .rsp_frame_length (rsp_frame_length),
      .rsp_close_reason (rsp_close_reason),
      .rsp_last         (rsp_last)
   );

   ufrm_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

// File: design/ufrm_checker.sv
module ufrm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [ufrm_pkg::BYTE_W-1:0]  rsp_out_byte,
   input logic [ufrm_pkg::ADDR_W-1:0]  rsp_out_index,
   input logic [ufrm_pkg::LEN_W-1:0]   rsp_frame_length,
   input logic                         rsp_last
);

   property p_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
            && $stable(rsp_out_index) && $stable(rsp_last);
   endproperty
   a_hold: assert property (p_hold) else $error("result word changed under stall");

   property p_last_pos;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_last == (({1'b0, rsp_out_index} + 7'd1) == rsp_frame_length));
   endproperty
   a_last_pos: assert property (p_last_pos) else $error("last mark off frame end");

   property p_next_index;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid
            && (rsp_out_index == $past(rsp_out_index) + 6'd1);
   endproperty
   a_next_index: assert property (p_next_index) else $error("frame drain gap or skip");

   property p_busy;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_last |-> req_stall;
   endproperty
   a_busy: assert property (p_busy) else $error("input taken mid drain");

endmodule

bind uart_rx_idle_timeout_framer_core ufrm_checker u_ufrm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_out_index    (rsp_out_index),
   .rsp_frame_length (rsp_frame_length),
   .rsp_last         (rsp_last)
);

// File: tb/uart_rx_idle_timeout_framer_core_tb.sv
`timescale 1ns / 1ps
module uart_rx_idle_timeout_framer_core_tb;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE      = 4;
   localparam int HOLD_CYCLES = 400;
   localparam int N_ROWS      = 31;
   localparam int N_PHASES    = 8;

   typedef struct packed {
      logic [7:0] data;
      logic [5:0] index;
      logic [6:0] length;
      logic       reason;
      logic       last;
   } frame_word_type;

   typedef enum logic [0:0] {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic         sel;
      logic [7:0]   data;
      int           reps;
      logic [6:0]   t_len;
      logic         t_reason;
   } step_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_command = ufrm_pkg::CMD_BYTE;
   logic [7:0]                     req_rx_byte = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [7:0]                     rsp_out_byte;
   logic [5:0]                     rsp_out_index;
   logic [6:0]                     rsp_frame_length;
   logic                           rsp_close_reason;
   logic                           rsp_last;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [ufrm_pkg::CSR_IDX_W-1:0] csr_index = ufrm_pkg::CSR_BUF_SIZE;
   logic [ufrm_pkg::CSR_DAT_W-1:0] csr_wdata = '0;

   logic [6:0]     cfg_size;
   logic [7:0]     cfg_tmo;
   logic           fr_open;
   logic [6:0]     fr_count;
   logic [7:0]     fr_idle;
   logic [7:0]     fr_store [ufrm_pkg::BUF_DEPTH];
   frame_word_type frame_q [$];

   step_row_type   script [N_ROWS];
   logic [7:0]  phase_size [N_PHASES] = '{8'h01, 8'h80, 8'h05, 8'h40, 8'h64, 8'h03, 8'h10, 8'h40};
   logic [7:0]  phase_tmo  [N_PHASES] = '{8'h01, 8'h02, 8'h00, 8'hFF, 8'h07, 8'h03, 8'h01, 8'h04};

   int   errors      = 0;
   int   word_count  = 0;
   int   cycle_count = 0;
   int   rsp_wait    = 0;
   logic rsp_hold    = 1'b0;
   bit   hold_go     = 1'b0;
   bit   quiet       = 1'b0;

   uart_rx_idle_timeout_framer_core uut (.*);

   always #10 clock = ~clock;

   function automatic int unsigned size_limit();
      if (cfg_size == '0) return 1;
      if (cfg_size > ufrm_pkg::BUF_DEPTH) return ufrm_pkg::BUF_DEPTH;
      return cfg_size;
   endfunction

   function automatic void close_frame(input logic reason, ref frame_word_type words[$]);
      frame_word_type w;
      for (int k = 0; k < fr_count; k++) begin
         w.data   = fr_store[k];
         w.index  = 6'(k);
         w.length = fr_count;
         w.reason = reason;
         w.last   = (k + 1 == fr_count);
         words.push_back(w);
      end
      fr_open  = 1'b0;
      fr_count = '0;
      fr_idle  = '0;
   endfunction

   function automatic void frame_step(input logic cmd, input logic [7:0] data,
                                      ref frame_word_type words[$]);
      if (cmd == ufrm_pkg::CMD_BYTE) begin
         if (!fr_open) begin
            fr_open  = 1'b1;
            fr_count = '0;
         end
         fr_idle = '0;
         word_count++;
         if (fr_count < size_limit()) begin
            fr_store[fr_count[5:0]] = data;
            fr_count++;
         end else begin
            close_frame(ufrm_pkg::REASON_FULL, words);
         end
      end else if (fr_open) begin
         word_count++;
         fr_idle = fr_idle + 8'd1;
         if (fr_idle >= cfg_tmo) close_frame(ufrm_pkg::REASON_TIMEOUT, words);
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endfunction

   task automatic send_word(input logic cmd, input logic [7:0] data,
                            input logic [6:0] t_len, input logic t_reason);
      int             gap;
      frame_word_type words [$];
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_rx_byte <= data;
      do @(posedge clock); while (req_stall);
      frame_step(cmd, data, words);
      foreach (words[i]) begin
         if (t_len != '0) begin
            words[i].length = t_len;
            words[i].reason = t_reason;
         end
         frame_q.push_back(words[i]);
      end
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      while (frame_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ufrm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] data);
      drain_wait();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == ufrm_pkg::CSR_BUF_SIZE) cfg_size = data[6:0];
      else cfg_tmo = data;
   endtask

   always @(posedge clock) begin : rsp_side
      frame_word_type want;
      if (reset) begin
         rsp_wait = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none, got byte %0d index %0d",
                        $time, rsp_out_byte, rsp_out_index);
            end else begin
               want = frame_q.pop_front();
               check_field("out_byte", want.data, rsp_out_byte);
               check_field("out_index", want.index, rsp_out_index);
               check_field("frame_length", want.length, rsp_frame_length);
               check_field("close_reason", want.reason, rsp_close_reason);
               check_field("last", want.last, rsp_last);
            end
            rsp_wait = quiet ? 0 : $urandom_range(0, 13);
         end else if (rsp_wait != 0) begin
            rsp_wait--;
         end
         rsp_stall <= rsp_hold || (rsp_wait != 0);
      end
   end

   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("uart_rx_idle_timeout_framer_core_tb failed");
         $finish;
      end
   end

   initial begin : stimulus
      step_row_type row;
      int           lim;
      int           n_bytes;
      int           n_ticks;
      int           budget;
      script = '{
         '{ROW_WORD, ufrm_pkg::CMD_TICK,     8'h00, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_BYTE,     8'h00, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_TICK,     8'h00, 3,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_TICK,     8'h00, 1,  7'd1,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_BYTE,     8'h80, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_BYTE,     8'h7F, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_TICK,     8'h00, 4,  7'd2,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_CSR,  ufrm_pkg::CSR_BUF_SIZE, 8'h00, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_CSR,  ufrm_pkg::CSR_TIMEOUT,  8'h00, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_BYTE,     8'hFF, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_BYTE,     8'hA5, 1,  7'd1,  ufrm_pkg::REASON_FULL},
         '{ROW_WORD, ufrm_pkg::CMD_BYTE,     8'h5A, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_TICK,     8'hFF, 1,  7'd1,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_CSR,  ufrm_pkg::CSR_BUF_SIZE, 8'hFF, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_CSR,  ufrm_pkg::CSR_TIMEOUT,  8'hFF, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_BYTE,     8'h00, 64, 7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_BYTE,     8'hC3, 1,  7'd64, ufrm_pkg::REASON_FULL},
         '{ROW_WORD, ufrm_pkg::CMD_TICK,     8'h00, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_CSR,  ufrm_pkg::CSR_TIMEOUT,  8'h03, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_BYTE,     8'h11, 6,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_CSR,  ufrm_pkg::CSR_BUF_SIZE, 8'h02, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_BYTE,     8'h22, 1,  7'd6,  ufrm_pkg::REASON_FULL},
         '{ROW_WORD, ufrm_pkg::CMD_BYTE,     8'h33, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_TICK,     8'h00, 2,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_BYTE,     8'h44, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_TICK,     8'h00, 2,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_TICK,     8'h00, 1,  7'd2,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_BYTE,     8'h55, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_TICK,     8'h00, 2,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_CSR,  ufrm_pkg::CSR_TIMEOUT,  8'h01, 1,  7'd0,  ufrm_pkg::REASON_TIMEOUT},
         '{ROW_WORD, ufrm_pkg::CMD_TICK,     8'h00, 1,  7'd1,  ufrm_pkg::REASON_TIMEOUT}
      };
      cfg_size = ufrm_pkg::BUF_SIZE_RESET;
      cfg_tmo  = ufrm_pkg::TIMEOUT_RESET;
      fr_open  = 1'b0;
      fr_count = '0;
      fr_idle  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_ROWS; r++) begin
         row = script[r];
         for (int k = 0; k < row.reps; k++) begin
            if (row.kind == ROW_CSR) write_csr(row.sel, row.data);
            else send_word(row.sel, row.data + 8'(k), row.t_len, row.t_reason);
         end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         write_csr(ufrm_pkg::CSR_BUF_SIZE, phase_size[p]);
         write_csr(ufrm_pkg::CSR_TIMEOUT, phase_tmo[p]);
         quiet = ($urandom_range(0, 3) == 0);
         // starve the result side while the sender keeps pushing frames
         if (p == 6) begin
            quiet   = 1'b1;
            hold_go = 1'b1;
         end
         budget = word_count + 35;
         while (word_count < budget) begin
            lim = size_limit();
            case ($urandom_range(0, 9))
               0: send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 7'd0,
                            ufrm_pkg::REASON_TIMEOUT);
               1: drain_wait();
               default: begin
                  n_bytes = ($urandom_range(0, 3) == 0) ? lim + 1 : $urandom_range(1, lim);
                  repeat (n_bytes) send_word(ufrm_pkg::CMD_BYTE, 8'($urandom_range(0, 255)),
                                             7'd0, ufrm_pkg::REASON_TIMEOUT);
                  n_ticks = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                        : cfg_tmo + $urandom_range(0, 1);
                  repeat (n_ticks) send_word(ufrm_pkg::CMD_TICK, 8'($urandom_range(0, 255)),
                                             7'd0, ufrm_pkg::REASON_TIMEOUT);
               end
            endcase
         end
      end

      drain_wait();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("uart_rx_idle_timeout_framer_core_tb passed");
      end else begin
         $display("uart_rx_idle_timeout_framer_core_tb failed");
      end
      $finish;
   end

endmodule
